@@ hw/rtl/quadratic_wire_estimate_top_assert.svh @@
// Assertion macros for the quadratic wire estimate block.
// Included by quadratic_wire_estimate_top; relies on clk and rst in scope.
`ifndef QUADRATIC_WIRE_ESTIMATE_TOP_ASSERT_SVH
`define QUADRATIC_WIRE_ESTIMATE_TOP_ASSERT_SVH

// Condition and consequence in the same cycle.
`define QWE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the cycle after the condition.
`define QWE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/qwe_pkg.sv @@
// Shared types and constants for the quadratic wire estimate block.
// No dependencies; imported by every module of the block.
`default_nettype none

package qwe_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 64;

  // 1.0 in Q1.16, the upper clamp of a normalized position.
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Register stages ahead of the output register, and the stage at
  // which the pin weights enter the fit units.
  localparam int PIPE_DEPTH = 9;
  localparam int PIN_DEPTH  = 5;

  // Side order used for every per-side array.
  localparam int SIDE_LEFT   = 0;
  localparam int SIDE_RIGHT  = 1;
  localparam int SIDE_BOTTOM = 2;
  localparam int SIDE_TOP    = 3;
  localparam int NUM_SIDES   = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COEF_CONST    = 4'd0,
    REG_COEF_X        = 4'd1,
    REG_COEF_XX       = 4'd2,
    REG_COEF_Y        = 4'd3,
    REG_COEF_YY       = 4'd4,
    REG_COEF_PINS     = 4'd5,
    REG_CORE_ORIGIN   = 4'd6,
    REG_CORE_INV_SPAN = 4'd7
  } reg_index_t;

  // Fit coefficients, all signed Q16.16.
  typedef struct packed {
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
    logic signed [31:0] c4;
    logic signed [31:0] c5;
  } coef_t;

endpackage

`default_nettype wire

@@ hw/rtl/qwe_norm.sv @@
// Three-stage normalization of one edge against the core origin.
// Depends on qwe_pkg for the Q1.16 clamp value.
`default_nettype none

module qwe_norm (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [31:0] edge_pos,
  input  logic signed [31:0] origin,
  input  logic        [31:0] inv,
  output logic        [16:0] norm
);
  import qwe_pkg::*;

  logic signed [32:0] diff;
  logic        [31:0] delta;
  logic               pos_a;
  logic        [63:0] prod;
  logic               pos_b;

  // Exact distance from the core origin; only a positive one normalizes.
  assign diff = {edge_pos[31], edge_pos} - {origin[31], origin};

  always_ff @(posedge clk) begin
    if (adv) begin
      delta <= diff[31:0];
      pos_a <= !diff[32] && (diff != '0);
      prod  <= 64'(delta) * 64'(inv);
      pos_b <= pos_a;
      if (!pos_b) begin
        norm <= '0;
      end else if (prod[63:16] > 48'(ONE_Q16)) begin
        norm <= ONE_Q16;
      end else begin
        norm <= prod[32:16];
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/qwe_fit.sv @@
// Four-stage quadratic fit c0 + (c1 + c2*x)*x + (c3 + c4*y)*y + c5*p.
// Depends on qwe_pkg for the coefficient struct.
`default_nettype none

module qwe_fit (
  input  logic                clk,
  input  logic                adv,
  input  qwe_pkg::coef_t      coef,
  input  logic         [16:0] x,
  input  logic         [16:0] y,
  input  logic signed  [15:0] pins,
  output logic signed  [48:0] fit
);
  import qwe_pkg::*;

  logic signed [17:0] xs;
  logic signed [17:0] ys;
  logic signed [17:0] x_a, y_a, x_b, y_b;
  logic signed [49:0] mx, my;
  logic signed [47:0] cp_a, cp_b, cp_c;
  logic signed [32:0] sx, sy;
  logic signed [50:0] ax_p, by_p;

  assign xs = $signed({1'b0, x});
  assign ys = $signed({1'b0, y});

  // The inner products shifted right by 16 stay within 32 signed bits,
  // the outer ones within 34, so the part-selects below lose nothing.
  always_ff @(posedge clk) begin
    if (adv) begin
      mx   <= coef.c2 * xs;
      my   <= coef.c4 * ys;
      cp_a <= coef.c5 * pins;
      x_a  <= xs;
      y_a  <= ys;

      sx   <= $signed({coef.c1[31], coef.c1}) + $signed({mx[47], mx[47:16]});
      sy   <= $signed({coef.c3[31], coef.c3}) + $signed({my[47], my[47:16]});
      cp_b <= cp_a;
      x_b  <= x_a;
      y_b  <= y_a;

      ax_p <= sx * x_b;
      by_p <= sy * y_b;
      cp_c <= cp_b;

      fit  <= $signed({{17{coef.c0[31]}}, coef.c0})
            + $signed({{15{ax_p[49]}}, ax_p[49:16]})
            + $signed({{15{by_p[49]}}, by_p[49:16]})
            + $signed({cp_c[47], cp_c});
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/quadratic_wire_estimate_top.sv @@
// Top level of the quadratic wire estimate block: request handshake,
// configuration registers, edge pipeline and output stage.
// Depends on qwe_pkg, qwe_norm, qwe_fit and the assertion macro header.
`default_nettype none

// Each request carries a tile box, a move offset and four per-side pin
// weights; the result is the moved box with every side pushed outward by
// a routing width from a quadratic fit of its normalized position and pin
// weight. The block accepts one request every clock cycle while the input
// is not stalled. Each request passes through these stages in order: one
// stage moves the box, three normalize the edges (subtract, 32x32 multiply,
// clamp), one averages the positions, four evaluate the fit (two rounds
// of multiply and add), and the output register applies the estimate with
// saturation. The whole pipeline advances together, so a stalled result
// holds every stage and the input is stalled only while a result waits at
// the output. A negative left pin weight or a zero x reciprocal span
// sends the moved box out unchanged through the same stages. Configuration
// registers are written through a plain write port, one register per
// index, and should only be written while no request is in flight;
// indexes beyond the register list are ignored.
module quadratic_wire_estimate_top (
  input  logic                            clk,
  input  logic                            rst,

  input  logic                            cfg_we,
  input  logic [qwe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [qwe_pkg::CFG_DATA_W-1:0]  cfg_data,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [31:0]              box_left,
  input  logic signed [31:0]              box_right,
  input  logic signed [31:0]              box_bottom,
  input  logic signed [31:0]              box_top,
  input  logic signed [31:0]              move_x,
  input  logic signed [31:0]              move_y,
  input  logic signed [15:0]              pins_left,
  input  logic signed [15:0]              pins_right,
  input  logic signed [15:0]              pins_bottom,
  input  logic signed [15:0]              pins_top,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              est_left,
  output logic signed [31:0]              est_right,
  output logic signed [31:0]              est_bottom,
  output logic signed [31:0]              est_top
);
  import qwe_pkg::*;

  `include "quadratic_wire_estimate_top_assert.svh"

  // Configuration registers.
  coef_t       coef;
  logic [63:0] core_origin;
  logic [63:0] core_inv_span;

  // Pipeline control: every stage moves when the output register is free
  // or is being emptied in this cycle.
  logic adv;
  logic v_q [PIPE_DEPTH];

  // Moved edges, bypass flag and pin weights travel beside the datapath.
  logic signed [31:0] moved    [NUM_SIDES];
  logic               byp_in;
  logic signed [31:0] edge_q   [PIPE_DEPTH][NUM_SIDES];
  logic               byp_q    [PIPE_DEPTH];
  logic signed [15:0] pins_q   [PIN_DEPTH][NUM_SIDES];

  // Normalized positions and the averaging stage.
  logic [16:0] norm_w [NUM_SIDES];
  logic [16:0] norm_q [NUM_SIDES];
  logic [16:0] xave_q;
  logic [16:0] yave_q;
  logic [17:0] sum_x;
  logic [17:0] sum_y;

  // Fit results and the output stage.
  logic signed [48:0] fit_w   [NUM_SIDES];
  logic        [31:0] route_w [NUM_SIDES];
  logic signed [33:0] wide_w  [NUM_SIDES];
  logic signed [31:0] res_w   [NUM_SIDES];

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Register writes; an index past the list leaves everything alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef          <= '0;
      core_origin   <= '0;
      core_inv_span <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_CONST:    coef.c0       <= cfg_data[31:0];
        REG_COEF_X:        coef.c1       <= cfg_data[31:0];
        REG_COEF_XX:       coef.c2       <= cfg_data[31:0];
        REG_COEF_Y:        coef.c3       <= cfg_data[31:0];
        REG_COEF_YY:       coef.c4       <= cfg_data[31:0];
        REG_COEF_PINS:     coef.c5       <= cfg_data[31:0];
        REG_CORE_ORIGIN:   core_origin   <= cfg_data;
        REG_CORE_INV_SPAN: core_inv_span <= cfg_data;
        default: ;
      endcase
    end
  end

  // First stage: the move wraps modulo 2^32. A cluster tile (negative left
  // pin weight) or a zero x reciprocal sends the moved box out unchanged.
  assign moved[SIDE_LEFT]   = box_left + move_x;
  assign moved[SIDE_RIGHT]  = box_right + move_x;
  assign moved[SIDE_BOTTOM] = box_bottom + move_y;
  assign moved[SIDE_TOP]    = box_top + move_y;
  assign byp_in = pins_left[15] || (core_inv_span[31:0] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (adv) begin
      v_q[0] <= in_valid;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      edge_q[0] <= moved;
      byp_q[0]  <= byp_in;
      pins_q[0][SIDE_LEFT]   <= pins_left;
      pins_q[0][SIDE_RIGHT]  <= pins_right;
      pins_q[0][SIDE_BOTTOM] <= pins_bottom;
      pins_q[0][SIDE_TOP]    <= pins_top;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        edge_q[i] <= edge_q[i-1];
        byp_q[i]  <= byp_q[i-1];
      end
      for (int i = 1; i < PIN_DEPTH; i++) begin
        pins_q[i] <= pins_q[i-1];
      end
    end
  end

  // Normalization: x sides against the core left, y sides against the
  // core bottom. A zero y reciprocal simply yields zero positions.
  qwe_norm u_norm_left (
    .clk      (clk),
    .adv      (adv),
    .edge_pos (edge_q[0][SIDE_LEFT]),
    .origin   (core_origin[31:0]),
    .inv      (core_inv_span[31:0]),
    .norm     (norm_w[SIDE_LEFT])
  );

  qwe_norm u_norm_right (
    .clk      (clk),
    .adv      (adv),
    .edge_pos (edge_q[0][SIDE_RIGHT]),
    .origin   (core_origin[31:0]),
    .inv      (core_inv_span[31:0]),
    .norm     (norm_w[SIDE_RIGHT])
  );

  qwe_norm u_norm_bottom (
    .clk      (clk),
    .adv      (adv),
    .edge_pos (edge_q[0][SIDE_BOTTOM]),
    .origin   (core_origin[63:32]),
    .inv      (core_inv_span[63:32]),
    .norm     (norm_w[SIDE_BOTTOM])
  );

  qwe_norm u_norm_top (
    .clk      (clk),
    .adv      (adv),
    .edge_pos (edge_q[0][SIDE_TOP]),
    .origin   (core_origin[63:32]),
    .inv      (core_inv_span[63:32]),
    .norm     (norm_w[SIDE_TOP])
  );

  // Averages of the two positions on each axis, truncated.
  assign sum_x = {1'b0, norm_w[SIDE_LEFT]} + {1'b0, norm_w[SIDE_RIGHT]};
  assign sum_y = {1'b0, norm_w[SIDE_BOTTOM]} + {1'b0, norm_w[SIDE_TOP]};

  always_ff @(posedge clk) begin
    if (adv) begin
      norm_q <= norm_w;
      xave_q <= sum_x[17:1];
      yave_q <= sum_y[17:1];
    end
  end

  // Left and right sides use their own x and the y average; bottom and
  // top use the x average and their own y.
  qwe_fit u_fit_left (
    .clk  (clk),
    .adv  (adv),
    .coef (coef),
    .x    (norm_q[SIDE_LEFT]),
    .y    (yave_q),
    .pins (pins_q[PIN_DEPTH-1][SIDE_LEFT]),
    .fit  (fit_w[SIDE_LEFT])
  );

  qwe_fit u_fit_right (
    .clk  (clk),
    .adv  (adv),
    .coef (coef),
    .x    (norm_q[SIDE_RIGHT]),
    .y    (yave_q),
    .pins (pins_q[PIN_DEPTH-1][SIDE_RIGHT]),
    .fit  (fit_w[SIDE_RIGHT])
  );

  qwe_fit u_fit_bottom (
    .clk  (clk),
    .adv  (adv),
    .coef (coef),
    .x    (xave_q),
    .y    (norm_q[SIDE_BOTTOM]),
    .pins (pins_q[PIN_DEPTH-1][SIDE_BOTTOM]),
    .fit  (fit_w[SIDE_BOTTOM])
  );

  qwe_fit u_fit_top (
    .clk  (clk),
    .adv  (adv),
    .coef (coef),
    .x    (xave_q),
    .y    (norm_q[SIDE_TOP]),
    .pins (pins_q[PIN_DEPTH-1][SIDE_TOP]),
    .fit  (fit_w[SIDE_TOP])
  );

  // Output stage. A negative fit gives no routing; otherwise the integer
  // part of the fit is the width. Left and bottom move down, right and
  // top move up, and a result beyond 32 signed bits saturates.
  always_comb begin
    for (int i = 0; i < NUM_SIDES; i++) begin
      route_w[i] = fit_w[i][48] ? '0 : fit_w[i][47:16];
      if (i == SIDE_LEFT || i == SIDE_BOTTOM) begin
        wide_w[i] = $signed({{2{edge_q[PIPE_DEPTH-1][i][31]}}, edge_q[PIPE_DEPTH-1][i]})
                  - $signed({2'b00, route_w[i]});
      end else begin
        wide_w[i] = $signed({{2{edge_q[PIPE_DEPTH-1][i][31]}}, edge_q[PIPE_DEPTH-1][i]})
                  + $signed({2'b00, route_w[i]});
      end
      if (byp_q[PIPE_DEPTH-1]) begin
        res_w[i] = edge_q[PIPE_DEPTH-1][i];
      end else if (wide_w[i][33:31] == 3'b000 || wide_w[i][33:31] == 3'b111) begin
        res_w[i] = wide_w[i][31:0];
      end else if (wide_w[i][33]) begin
        res_w[i] = 32'sh8000_0000;
      end else begin
        res_w[i] = 32'sh7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v_q[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      est_left   <= res_w[SIDE_LEFT];
      est_right  <= res_w[SIDE_RIGHT];
      est_bottom <= res_w[SIDE_BOTTOM];
      est_top    <= res_w[SIDE_TOP];
    end
  end

  // A bypassed request leaves the block with its moved box untouched.
  `QWE_ASSERT_NEXT(a_bypass_keeps_box, adv && v_q[PIPE_DEPTH-1] && byp_q[PIPE_DEPTH-1], out_valid && est_left == $past(edge_q[PIPE_DEPTH-1][SIDE_LEFT]) && est_top == $past(edge_q[PIPE_DEPTH-1][SIDE_TOP]), "bypassed request changed its box")
  // The estimate only ever widens the box.
  `QWE_ASSERT_NEXT(a_box_widens, adv && v_q[PIPE_DEPTH-1] && !byp_q[PIPE_DEPTH-1], est_left <= $past(edge_q[PIPE_DEPTH-1][SIDE_LEFT]) && est_right >= $past(edge_q[PIPE_DEPTH-1][SIDE_RIGHT]), "estimate moved a side inward")
  // A bubble in the last stage never turns into a result.
  `QWE_ASSERT_NEXT(a_no_phantom, adv && !v_q[PIPE_DEPTH-1], !out_valid, "result without a request")
  // The input stalls only behind a result that is waiting.
  `QWE_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with a free output")

endmodule

`default_nettype wire
